FILE: rtl/core/rcrq_pkg.sv
package rcrq_pkg;

  // Default sizing, handed down from the top level
  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned ELEMENT_BYTES_DEF = 8;

  // Field widths of the stream payloads
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DROPS_W  = 32;

  // Input tdata layout, lowest field first
  localparam int unsigned IN_MODE_LSB  = 0;
  localparam int unsigned IN_SLOT_LSB  = IN_MODE_LSB + MODE_W;
  localparam int unsigned IN_DATA_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_COUNT_LSB = IN_DATA_LSB + DATA_W;
  localparam int unsigned IN_USED_W    = IN_COUNT_LSB + COUNT_W;
  localparam int unsigned IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest field first
  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_SLOT_LSB   = OUT_STATUS_LSB + STATUS_W;
  localparam int unsigned OUT_DATA_LSB   = OUT_SLOT_LSB + SLOT_W;
  localparam int unsigned OUT_DROPS_LSB  = OUT_DATA_LSB + DATA_W;
  localparam int unsigned OUT_USED_W     = OUT_DROPS_LSB + DROPS_W;
  localparam int unsigned OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Pointer and counter updates requested by the sequencer
  typedef struct packed {
    logic reserve_ok;
    logic drop;
    logic deq_ok;
  } ring_upd_t;

endpackage

FILE: rtl/core/rcrq_slot_mem.sv
module rcrq_slot_mem #(
  parameter int unsigned DEPTH  = rcrq_pkg::DEPTH_DEF,
  parameter int unsigned WORD_W = 8 * rcrq_pkg::ELEMENT_BYTES_DEF + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  output logic                     clr_busy
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              clr_busy_r;
  logic              clr_busy_nxt;
  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     clr_addr_nxt;

  // Sweep every entry to zero after reset, one a cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: rtl/core/rcrq_ring.sv
module rcrq_ring #(
  parameter int unsigned DEPTH = rcrq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rcrq_pkg::ring_upd_t            upd,
  output logic                           full,
  output logic [$clog2(DEPTH)-1:0]       head,
  output logic [$clog2(DEPTH)-1:0]       tail,
  output logic [rcrq_pkg::DROPS_W-1:0]   drops_nxt
);

  import rcrq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  logic [OW-1:0]      occ_r;
  logic [OW-1:0]      occ_nxt;
  logic [PW-1:0]      head_r;
  logic [PW-1:0]      head_nxt;
  logic [PW-1:0]      tail_r;
  logic [PW-1:0]      tail_nxt;
  logic [DROPS_W-1:0] drops_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    occ_nxt   = occ_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    drops_nxt = drops_r;
    if (upd.reserve_ok) begin
      occ_nxt  = occ_r + 1'b1;
      tail_nxt = wrap_inc(tail_r);
    end
    if (upd.drop) begin
      drops_nxt = drops_r + 1'b1;
    end
    if (upd.deq_ok) begin
      head_nxt = wrap_inc(head_r);
      // hold at zero when an unreserved slot was committed and dequeued
      if (occ_r != '0) begin
        occ_nxt = occ_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      drops_r <= '0;
    end else begin
      occ_r   <= occ_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      drops_r <= drops_nxt;
    end
  end

  assign full = (occ_r == OW'(DEPTH));
  assign head = head_r;
  assign tail = tail_r;

endmodule

FILE: rtl/core/reserve_commit_ring_queue.sv
// Channel | Ports                               | Transaction
// --------+-------------------------------------+-------------------------------------------
// input   | in_tvalid / in_tready / in_tdata    | one operation: reserve, commit or dequeue
// output  | out_tvalid / out_tready / out_tdata | one result per operation, in order
//
// Each transaction reads the slot memory on the accepting edge, then modifies and writes back
// in the execute state; in_tready stays low meanwhile, so no read overtakes a pending write-back.
// After reset the slot memory is swept to zero, one entry at a time; in_tready stays low
// until the sweep is done.
// A result held in the output register does not block acceptance; only a second
// result meeting a still-full output register waits in the execute cycle.
module reserve_commit_ring_queue #(
  parameter int unsigned DEPTH         = rcrq_pkg::DEPTH_DEF,
  parameter int unsigned ELEMENT_BYTES = rcrq_pkg::ELEMENT_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // mode[1:0], slot_index[5:2], data_word[69:6], byte_count[73:70], zero fill above
  input  logic [rcrq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], granted_slot[5:2], data_out[69:6], drops_total[101:70], zero fill above
  output logic [rcrq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import rcrq_pkg::*;

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DW     = 8 * ELEMENT_BYTES;
  localparam int unsigned WORD_W = DW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Operation captured at acceptance
  logic [MODE_W-1:0]  op_mode_r;
  logic [SLOT_W-1:0]  op_slot_r;
  logic [DATA_W-1:0]  op_data_r;
  logic [COUNT_W-1:0] op_count_r;

  // Output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [DROPS_W-1:0]  out_drops_r;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [DATA_W-1:0]   res_data;

  logic                in_fire;
  logic                exec_fire;
  logic [MODE_W-1:0]   in_mode;
  logic [SLOT_W-1:0]   in_slot;

  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [WORD_W-1:0]   mem_rd_data;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [WORD_W-1:0]   mem_wr_data;
  logic                clr_busy;

  ring_upd_t           upd;
  logic                ring_full;
  logic [AW-1:0]       ring_head;
  logic [AW-1:0]       ring_tail;
  logic [DROPS_W-1:0]  drops_nxt;

  logic                slot_ok;
  logic [DW-1:0]       merged;

  assign in_mode   = in_tdata[IN_MODE_LSB +: MODE_W];
  assign in_slot   = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // finish the operation once the output register can take its result
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // Read the target entry on the accepting edge: the committed slot, else the head
  assign mem_rd_en   = in_fire;
  assign mem_rd_addr = (in_mode == MODE_COMMIT) ? AW'(in_slot) : ring_head;

  assign slot_ok = (32'(op_slot_r) < 32'(DEPTH));

  // Overwrite the bytes below the count, keep the rest; counts above the
  // element size simply cover every byte
  always_comb begin
    merged = mem_rd_data[DW-1:0];
    for (int b = 0; b < ELEMENT_BYTES; b++) begin
      if (COUNT_W'(b) < op_count_r) begin
        merged[8*b +: 8] = op_data_r[8*b +: 8];
      end
    end
  end

  // Modify and write back in the execute cycle
  always_comb begin
    upd         = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ring_head;
    mem_wr_data = {1'b0, mem_rd_data[DW-1:0]};
    res_status  = STATUS_OK;
    res_slot    = '0;
    res_data    = '0;
    unique case (op_mode_r)
      MODE_RESERVE: begin
        if (ring_full) begin
          upd.drop   = exec_fire;
          res_status = STATUS_FULL;
        end else begin
          upd.reserve_ok = exec_fire;
          res_slot       = SLOT_W'(ring_tail);
        end
      end
      MODE_COMMIT: begin
        // drop commits aimed past the last slot
        if (slot_ok) begin
          mem_wr_en   = exec_fire;
          mem_wr_addr = AW'(op_slot_r);
          mem_wr_data = {1'b1, merged};
        end
      end
      MODE_DEQUEUE: begin
        if (mem_rd_data[DW]) begin
          // clear the ready mark, keep the data
          mem_wr_en  = exec_fire;
          upd.deq_ok = exec_fire;
          res_data   = DATA_W'(mem_rd_data[DW-1:0]);
        end else begin
          res_status = STATUS_EMPTY;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on acceptance, load the result on completion
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_mode_r  <= in_mode;
      op_slot_r  <= in_slot;
      op_data_r  <= in_tdata[IN_DATA_LSB +: DATA_W];
      op_count_r <= in_tdata[IN_COUNT_LSB +: COUNT_W];
    end
    if (exec_fire) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_data_r   <= res_data;
      out_drops_r  <= drops_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                                   = '0;
    out_tdata[OUT_STATUS_LSB +: STATUS_W]       = out_status_r;
    out_tdata[OUT_SLOT_LSB +: SLOT_W]           = out_slot_r;
    out_tdata[OUT_DATA_LSB +: DATA_W]           = out_data_r;
    out_tdata[OUT_DROPS_LSB +: DROPS_W]         = out_drops_r;
  end

  rcrq_slot_mem #(
    .DEPTH  (DEPTH),
    .WORD_W (WORD_W)
  ) u_slot_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_data  (mem_rd_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .clr_busy (clr_busy)
  );

  rcrq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .full      (ring_full),
    .head      (ring_head),
    .tail      (ring_tail),
    .drops_nxt (drops_nxt)
  );

endmodule
